/* rtl/fsbe_pkg.sv */
package fsbe_pkg;

    localparam int unsigned WORD_W          = 16;
    localparam int unsigned BLOCK_W         = 64;
    localparam int unsigned KEY_W           = 64;
    localparam int unsigned NUM_WORDS       = 4;
    localparam int unsigned FETCH_PER_ROUND = 12;
    localparam int unsigned ROUND_COUNT_DEF = 16;

    typedef logic [WORD_W-1:0]                 word_t;
    typedef logic [NUM_WORDS-1:0][WORD_W-1:0]  words_t;
    typedef logic [7:0]                        byte_t;

    localparam byte_t FTAB [256] = '{
        8'ha3, 8'hd7, 8'h09, 8'h83, 8'hf8, 8'h48, 8'hf6, 8'hf4,
        8'hb3, 8'h21, 8'h15, 8'h78, 8'h99, 8'hb1, 8'haf, 8'hf9,
        8'he7, 8'h2d, 8'h4d, 8'h8a, 8'hce, 8'h4c, 8'hca, 8'h2e,
        8'h52, 8'h95, 8'hd9, 8'h1e, 8'h4e, 8'h38, 8'h44, 8'h28,
        8'h0a, 8'hdf, 8'h02, 8'ha0, 8'h17, 8'hf1, 8'h60, 8'h68,
        8'h12, 8'hb7, 8'h7a, 8'hc3, 8'he9, 8'hfa, 8'h3d, 8'h53,
        8'h96, 8'h84, 8'h6b, 8'hba, 8'hf2, 8'h63, 8'h9a, 8'h19,
        8'h7c, 8'hae, 8'he5, 8'hf5, 8'hf7, 8'h16, 8'h6a, 8'ha2,
        8'h39, 8'hb6, 8'h7b, 8'h0f, 8'hc1, 8'h93, 8'h81, 8'h1b,
        8'hee, 8'hb4, 8'h1a, 8'hea, 8'hd0, 8'h91, 8'h2f, 8'hb8,
        8'h55, 8'hb9, 8'hda, 8'h85, 8'h3f, 8'h41, 8'hbf, 8'he0,
        8'h5a, 8'h58, 8'h80, 8'h5f, 8'h66, 8'h0b, 8'hd8, 8'h90,
        8'h35, 8'hd5, 8'hc0, 8'ha7, 8'h33, 8'h06, 8'h65, 8'h69,
        8'h45, 8'h00, 8'h94, 8'h56, 8'h6d, 8'h98, 8'h9b, 8'h76,
        8'h97, 8'hfc, 8'hb2, 8'hc2, 8'hb0, 8'hfe, 8'hdb, 8'h20,
        8'he1, 8'heb, 8'hd6, 8'he4, 8'hdd, 8'h47, 8'h4a, 8'h1d,
        8'h42, 8'hed, 8'h9e, 8'h6e, 8'h49, 8'h3c, 8'hcd, 8'h43,
        8'h27, 8'hd2, 8'h07, 8'hd4, 8'hde, 8'hc7, 8'h67, 8'h18,
        8'h89, 8'hcb, 8'h30, 8'h1f, 8'h8d, 8'hc6, 8'h8f, 8'haa,
        8'hc8, 8'h74, 8'hdc, 8'hc9, 8'h5d, 8'h5c, 8'h31, 8'ha4,
        8'h70, 8'h88, 8'h61, 8'h2c, 8'h9f, 8'h0d, 8'h2b, 8'h87,
        8'h50, 8'h82, 8'h54, 8'h64, 8'h26, 8'h7d, 8'h03, 8'h40,
        8'h34, 8'h4b, 8'h1c, 8'h73, 8'hd1, 8'hc4, 8'hfd, 8'h3b,
        8'hcc, 8'hfb, 8'h7f, 8'hab, 8'he6, 8'h3e, 8'h5b, 8'ha5,
        8'had, 8'h04, 8'h23, 8'h9c, 8'h14, 8'h51, 8'h22, 8'hf0,
        8'h29, 8'h79, 8'h71, 8'h7e, 8'hff, 8'h8c, 8'h0e, 8'he2,
        8'h0c, 8'hef, 8'hbc, 8'h72, 8'h75, 8'h6f, 8'h37, 8'ha1,
        8'hec, 8'hd3, 8'h8e, 8'h62, 8'h8b, 8'h86, 8'h10, 8'he8,
        8'h08, 8'h77, 8'h11, 8'hbe, 8'h92, 8'h4f, 8'h24, 8'hc5,
        8'h32, 8'h36, 8'h9d, 8'hcf, 8'hf3, 8'ha6, 8'hbb, 8'hac,
        8'h5e, 8'h6c, 8'ha9, 8'h13, 8'h57, 8'h25, 8'hb5, 8'he3,
        8'hbd, 8'ha8, 8'h3a, 8'h01, 8'h05, 8'h59, 8'h2a, 8'h46
    };

    // key byte for fetch number fetch (0..11) of round rnd; constant args give plain wiring
    function automatic byte_t key_byte(input logic [KEY_W-1:0] key,
                                       input int unsigned rnd,
                                       input int unsigned fetch);
        logic [2*KEY_W-1:0] dbl;
        logic [KEY_W-1:0]   rot;
        logic [5:0]         amt;
        logic [2:0]         sel;
        dbl = {key, key};
        amt = 6'(FETCH_PER_ROUND * rnd + fetch + 1);
        sel = 3'(4 * rnd + (fetch & 3));
        rot = dbl[2*KEY_W-1-int'(amt) -: KEY_W];
        return rot[{sel, 3'b000} +: 8];
    endfunction

endpackage

/* rtl/fsbe_plain_if.sv */
interface fsbe_plain_if;
    logic                         valid;
    logic                         ready;
    logic [fsbe_pkg::BLOCK_W-1:0] plain_block;

    modport source (output valid, output plain_block, input ready);
    modport sink   (input valid, input plain_block, output ready);
endinterface

/* rtl/fsbe_cipher_if.sv */
interface fsbe_cipher_if;
    logic                         valid;
    logic                         ready;
    logic [fsbe_pkg::BLOCK_W-1:0] cipher_block;

    modport source (output valid, output cipher_block, input ready);
    modport sink   (input valid, input cipher_block, output ready);
endinterface

/* rtl/fsbe_round.sv */
module fsbe_round #(
    parameter int unsigned RND = 0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic [fsbe_pkg::KEY_W-1:0]   key,
    input  logic                         in_vld,
    input  fsbe_pkg::words_t             in_words,
    output logic                         out_vld,
    output fsbe_pkg::words_t             out_words
);

    fsbe_pkg::byte_t kb [fsbe_pkg::FETCH_PER_ROUND];

    always_comb
    begin
        for (int j = 0; j < int'(fsbe_pkg::FETCH_PER_ROUND); j++)
        begin
            kb[j] = fsbe_pkg::key_byte(key, RND, j);
        end
    end

    // stage 1: first two lookups of both g permutations
    fsbe_pkg::byte_t  a0_next, b0_next, a1_next, b1_next;
    fsbe_pkg::byte_t  a0_reg, b0_reg, a1_reg, b1_reg;
    fsbe_pkg::words_t s1_words_reg;
    logic             s1_vld_reg;

    always_comb
    begin
        a0_next = fsbe_pkg::FTAB[in_words[0][7:0] ^ kb[0]] ^ in_words[0][15:8];
        b0_next = fsbe_pkg::FTAB[a0_next ^ kb[1]] ^ in_words[0][7:0];
        a1_next = fsbe_pkg::FTAB[in_words[1][7:0] ^ kb[4]] ^ in_words[1][15:8];
        b1_next = fsbe_pkg::FTAB[a1_next ^ kb[5]] ^ in_words[1][7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a0_reg       <= a0_next;
            b0_reg       <= b0_next;
            a1_reg       <= a1_next;
            b1_reg       <= b1_next;
            s1_words_reg <= in_words;
        end
    end

    // stage 2: last two lookups
    fsbe_pkg::word_t  t0_next, t1_next, t0_reg, t1_reg;
    fsbe_pkg::byte_t  c0, c1;
    fsbe_pkg::words_t s2_words_reg;
    logic             s2_vld_reg;

    always_comb
    begin
        c0      = fsbe_pkg::FTAB[b0_reg ^ kb[2]] ^ a0_reg;
        t0_next = {c0, fsbe_pkg::FTAB[c0 ^ kb[3]] ^ b0_reg};
        c1      = fsbe_pkg::FTAB[b1_reg ^ kb[6]] ^ a1_reg;
        t1_next = {c1, fsbe_pkg::FTAB[c1 ^ kb[7]] ^ b1_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t0_reg       <= t0_next;
            t1_reg       <= t1_next;
            s2_words_reg <= s1_words_reg;
        end
    end

    // stage 3: f mix and feistel swap
    fsbe_pkg::word_t  f0, f1, x0;
    fsbe_pkg::words_t words_next, words_reg;
    logic             vld_reg;

    always_comb
    begin
        f0 = {kb[8], kb[9]} + t0_reg + {t1_reg[14:0], 1'b0};
        f1 = {kb[10], kb[11]} + {t0_reg[14:0], 1'b0} + t1_reg;
        x0 = s2_words_reg[2] ^ f0;
        words_next[0] = {x0[0], x0[15:1]};
        words_next[1] = {s2_words_reg[3][14:0], s2_words_reg[3][15]} ^ f1;
        words_next[2] = s2_words_reg[0];
        words_next[3] = s2_words_reg[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            words_reg <= words_next;
        end
    end

    assign out_vld   = vld_reg;
    assign out_words = words_reg;

endmodule

/* rtl/feistel_sbox_block_encrypt_64.sv */
// path: input whitening register, rounds of three register stages of table lookups and adds,
// then output whitening register; throughput: one word per cycle except while stalled
// the whole pipeline advances together and holds while the output word waits to be taken
// reset: asynchronous active low, clears all valid bits and the key register to zero
module feistel_sbox_block_encrypt_64 #(
    parameter int unsigned ROUND_COUNT = fsbe_pkg::ROUND_COUNT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [fsbe_pkg::KEY_W-1:0]  cfg_data,
    fsbe_plain_if.sink                  plain_in,
    fsbe_cipher_if.source               cipher_out
);

    logic [fsbe_pkg::KEY_W-1:0] key_reg;
    logic                       adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cfg_we)
        begin
            key_reg <= cfg_data;
        end
    end

    fsbe_pkg::words_t key_words;
    assign key_words = key_reg;

    // input whitening stage
    fsbe_pkg::words_t in_words_next, in_words_reg;
    logic             in_vld_reg;

    always_comb
    begin
        for (int i = 0; i < int'(fsbe_pkg::NUM_WORDS); i++)
        begin
            in_words_next[i] = plain_in.plain_block[fsbe_pkg::BLOCK_W-1-16*i -: 16]
                             ^ key_reg[fsbe_pkg::KEY_W-1-16*i -: 16];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            in_vld_reg <= plain_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_words_reg <= in_words_next;
        end
    end

    logic [ROUND_COUNT:0] rnd_vld;
    fsbe_pkg::words_t     rnd_words [ROUND_COUNT+1];

    assign rnd_vld[0]   = in_vld_reg;
    assign rnd_words[0] = in_words_reg;

    for (genvar g = 0; g < ROUND_COUNT; g++)
    begin : g_round
        fsbe_round #(
            .RND (g)
        ) u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .key       (key_reg),
            .in_vld    (rnd_vld[g]),
            .in_words  (rnd_words[g]),
            .out_vld   (rnd_vld[g+1]),
            .out_words (rnd_words[g+1])
        );
    end

    // output whitening stage with word pairs swapped back
    logic [fsbe_pkg::BLOCK_W-1:0] out_block_next, out_block_reg;
    logic                         out_vld_reg;
    fsbe_pkg::words_t             last_words;

    assign last_words = rnd_words[ROUND_COUNT];

    always_comb
    begin
        out_block_next = {last_words[2] ^ key_words[3], last_words[3] ^ key_words[2],
                          last_words[0] ^ key_words[1], last_words[1] ^ key_words[0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= rnd_vld[ROUND_COUNT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_block_reg <= out_block_next;
        end
    end

    assign adv                     = !out_vld_reg || cipher_out.ready;
    assign plain_in.ready          = adv;
    assign cipher_out.valid        = out_vld_reg;
    assign cipher_out.cipher_block = out_block_reg;

`ifndef SYNTH
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        plain_in.valid && plain_in.ready |=> in_vld_reg)
        else $error("accepted word not captured by input stage");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(rnd_vld) && $stable(in_vld_reg))
        else $error("pipeline valid bits moved during stall");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(rnd_vld[ROUND_COUNT]))
        else $error("output word without a word leaving the last round");
`endif

endmodule
